[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

[rtl/mma_pkg.sv]
`timescale 1ns / 1ps
package mma_pkg;

  localparam int MAX_DIM   = 64;
  localparam int ELEM_BITS = 16;
  localparam int ACC_BITS  = 40;

  localparam int OP_W      = 3;
  localparam int COORD_W   = 6;
  localparam int DIM_REG_W = 7;
  localparam int CFG_AW    = 4;
  localparam int CFG_DW    = 32;

  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int CNT_W  = $clog2(MAX_DIM + 1);
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PROD_W = 2 * ELEM_BITS;
  localparam int SUM_W  = ((ACC_BITS > PROD_W) ? ACC_BITS : PROD_W) + 1;
  localparam int CWORD_W = ACC_BITS + 1;

  localparam logic signed [SUM_W-1:0] SAT_HI =
    {{(SUM_W - ACC_BITS + 1){1'b0}}, {(ACC_BITS - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_A  = 3'd0,
    OP_LOAD_B  = 3'd1,
    OP_LOAD_C  = 3'd2,
    OP_COMPUTE = 3'd3,
    OP_READ_C  = 3'd4
  } mma_op_e;

  typedef enum logic [1:0] {
    REG_ROWS  = 2'd0,
    REG_COLS  = 2'd1,
    REG_INNER = 2'd2
  } mma_reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CRD,
    ST_RUN,
    ST_WB
  } mma_state_e;

  typedef struct packed {
    logic load;
    logic mul_v;
  } mma_mac_ctrl_t;

  function automatic logic [ADDR_W-1:0] mma_addr(input logic [IDX_W-1:0] r,
                                                 input logic [IDX_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c);
  endfunction

  function automatic logic [CNT_W-1:0] mma_dim(input logic [DIM_REG_W-1:0] r);
    return (int'(r) > MAX_DIM) ? CNT_W'(MAX_DIM) : CNT_W'(r);
  endfunction

endpackage

[rtl/mma_operand_mem.sv]
`timescale 1ns / 1ps
module mma_operand_mem (
  input  logic                                  clk_i,
  input  logic                                  we_a_i,
  input  logic                                  we_b_i,
  input  logic        [mma_pkg::ADDR_W-1:0]     waddr_i,
  input  logic signed [mma_pkg::ELEM_BITS-1:0]  wdata_i,
  input  logic                                  re_i,
  input  logic        [mma_pkg::ADDR_W-1:0]     raddr_a_i,
  input  logic        [mma_pkg::ADDR_W-1:0]     raddr_b_i,
  output logic signed [mma_pkg::ELEM_BITS-1:0]  rdata_a_o,
  output logic signed [mma_pkg::ELEM_BITS-1:0]  rdata_b_o
);
  import mma_pkg::*;

  logic signed [ELEM_BITS-1:0] a_mem [DEPTH];
  logic signed [ELEM_BITS-1:0] b_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_a_i) begin
      a_mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= a_mem[raddr_a_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_b_i) begin
      b_mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_b_o <= b_mem[raddr_b_i];
    end
  end

endmodule

[rtl/mma_accum_mem.sv]
`timescale 1ns / 1ps
module mma_accum_mem (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [mma_pkg::ADDR_W-1:0]     waddr_i,
  input  logic [mma_pkg::CWORD_W-1:0]    wdata_i,
  input  logic                           re_i,
  input  logic [mma_pkg::ADDR_W-1:0]     raddr_i,
  output logic [mma_pkg::CWORD_W-1:0]    rdata_o
);
  import mma_pkg::*;

  // word = {sticky flag, accumulator}
  logic [CWORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

[rtl/mma_mac.sv]
`timescale 1ns / 1ps
module mma_mac (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  mma_pkg::mma_mac_ctrl_t               ctrl_i,
  input  logic signed [mma_pkg::ELEM_BITS-1:0] a_i,
  input  logic signed [mma_pkg::ELEM_BITS-1:0] b_i,
  input  logic signed [mma_pkg::ACC_BITS-1:0]  c_acc_i,
  input  logic                                 c_flag_i,
  output logic signed [mma_pkg::ACC_BITS-1:0]  acc_o,
  output logic                                 flag_o,
  output logic                                 busy_o
);
  import mma_pkg::*;

  logic signed [PROD_W-1:0]   prod_q;
  logic                       prod_v_q;
  logic signed [ACC_BITS-1:0] acc_q, acc_d;
  logic                       flag_q, flag_d;
  logic signed [SUM_W-1:0]    sum;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_v) begin
      prod_q <= a_i * b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
    end else begin
      prod_v_q <= ctrl_i.mul_v;
    end
  end

  always_comb begin
    sum    = SUM_W'(acc_q) + SUM_W'(prod_q);
    acc_d  = acc_q;
    flag_d = flag_q;
    if (ctrl_i.load) begin
      acc_d  = c_acc_i;
      flag_d = c_flag_i;
    end else if (prod_v_q) begin
      if (sum > SAT_HI) begin
        acc_d  = SAT_HI[ACC_BITS-1:0];
        flag_d = 1'b1;
      end else if (sum < SAT_LO) begin
        acc_d  = SAT_LO[ACC_BITS-1:0];
        flag_d = 1'b1;
      end else begin
        acc_d = sum[ACC_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    flag_q <= flag_d;
  end

  assign acc_o  = acc_q;
  assign flag_o = flag_q;
  assign busy_o = prod_v_q;

endmodule

[rtl/matrix_multiply_accumulate.sv]
`timescale 1ns / 1ps
// C += A x B on signed Q1.15 elements with 40-bit saturating accumulators and a
// sticky overflow flag per C entry. After reset busy stays high while the C store
// is cleared. Loads, reads and unused op codes do not raise busy and may be issued
// back to back. A read returns its word on sum_value_o/overflowed_o in the cycle
// after it is accepted, marked by result_valid_o for exactly one cycle; the
// receiver cannot stall it. A compute holds busy while it runs (not at all when m
// or n is zero): one C entry at a time through a single multiply-accumulate unit
// fed by one A and one B read per cycle, with a C read and a C write-back around
// each entry.
module matrix_multiply_accumulate (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic        [mma_pkg::OP_W-1:0]      op_i,
  input  logic        [mma_pkg::COORD_W-1:0]   row_i,
  input  logic        [mma_pkg::COORD_W-1:0]   col_i,
  input  logic signed [mma_pkg::ELEM_BITS-1:0] element_i,
  input  logic signed [mma_pkg::ACC_BITS-1:0]  acc_init_i,
  output logic                                 result_valid_o,
  output logic signed [mma_pkg::ACC_BITS-1:0]  sum_value_o,
  output logic                                 overflowed_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic        [mma_pkg::CFG_AW-1:0]    paddr,
  input  logic        [mma_pkg::CFG_DW-1:0]    pwdata,
  output logic        [mma_pkg::CFG_DW-1:0]    prdata,
  output logic                                 pready
);
  import mma_pkg::*;

  // config
  logic [DIM_REG_W-1:0] rows_q, cols_q, inner_q;
  logic                 cfg_we;
  mma_reg_e             cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign cfg_idx = mma_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= DIM_REG_W'(1);
      cols_q  <= DIM_REG_W'(1);
      inner_q <= DIM_REG_W'(1);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ROWS:  rows_q  <= pwdata[DIM_REG_W-1:0];
        REG_COLS:  cols_q  <= pwdata[DIM_REG_W-1:0];
        REG_INNER: inner_q <= pwdata[DIM_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ROWS:  prdata = CFG_DW'(rows_q);
      REG_COLS:  prdata = CFG_DW'(cols_q);
      REG_INNER: prdata = CFG_DW'(inner_q);
      default:   prdata = '0;
    endcase
  end

  logic [CNT_W-1:0] m_eff, n_eff, k_eff;
  assign m_eff = mma_dim(rows_q);
  assign n_eff = mma_dim(cols_q);
  assign k_eff = mma_dim(inner_q);

  // control
  mma_state_e        state_q, state_d;
  logic [IDX_W-1:0]  i_q, i_d, j_q, j_d;
  logic [CNT_W-1:0]  p_q, p_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic              v1_q, c_ld_q, rd_v_q, in_range_q;
  logic              accept, in_range, issue;
  logic [ADDR_W-1:0] in_addr;

  logic                       op_we_a, op_we_b;
  logic [ADDR_W-1:0]          op_raddr_a, op_raddr_b;
  logic signed [ELEM_BITS-1:0] a_rd, b_rd;

  logic                c_we, c_re;
  logic [ADDR_W-1:0]   c_waddr, c_raddr;
  logic [CWORD_W-1:0]  c_wdata, c_rd;

  mma_mac_ctrl_t              mac_ctrl;
  logic signed [ACC_BITS-1:0] mac_acc;
  logic                       mac_flag, mac_busy;

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start & ~busy;
  assign in_range = (int'(row_i) < MAX_DIM) && (int'(col_i) < MAX_DIM);
  assign in_addr  = mma_addr(IDX_W'(row_i), IDX_W'(col_i));

  always_comb begin
    state_d    = state_q;
    i_d        = i_q;
    j_d        = j_q;
    p_d        = p_q;
    clr_d      = clr_q;
    issue      = 1'b0;
    op_we_a    = 1'b0;
    op_we_b    = 1'b0;
    op_raddr_a = mma_addr(i_q, IDX_W'(p_q));
    op_raddr_b = mma_addr(IDX_W'(p_q), j_q);
    c_we       = 1'b0;
    c_waddr    = in_addr;
    c_wdata    = {1'b0, acc_init_i};
    c_re       = 1'b0;
    c_raddr    = in_addr;
    case (state_q)
      ST_CLEAR: begin
        c_we    = 1'b1;
        c_waddr = clr_q;
        c_wdata = '0;
        clr_d   = clr_q + 1'b1;
        if (clr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (mma_op_e'(op_i))
            OP_LOAD_A:  op_we_a = in_range;
            OP_LOAD_B:  op_we_b = in_range;
            OP_LOAD_C:  c_we    = in_range;
            OP_READ_C:  c_re    = 1'b1;
            OP_COMPUTE: begin
              i_d = '0;
              j_d = '0;
              if (m_eff != '0 && n_eff != '0) begin
                state_d = ST_CRD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CRD: begin
        c_re    = 1'b1;
        c_raddr = mma_addr(i_q, j_q);
        p_d     = '0;
        state_d = ST_RUN;
      end
      ST_RUN: begin
        if (p_q < k_eff) begin
          issue = 1'b1;
          p_d   = p_q + 1'b1;
        end else if (!v1_q && !mac_busy) begin
          state_d = ST_WB;
        end
      end
      ST_WB: begin
        c_we    = 1'b1;
        c_waddr = mma_addr(i_q, j_q);
        c_wdata = {mac_flag, mac_acc};
        state_d = ST_CRD;
        if (CNT_W'(j_q) == n_eff - CNT_W'(1)) begin
          j_d = '0;
          if (CNT_W'(i_q) == m_eff - CNT_W'(1)) begin
            state_d = ST_IDLE;
          end else begin
            i_d = i_q + 1'b1;
          end
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      i_q        <= '0;
      j_q        <= '0;
      p_q        <= '0;
      clr_q      <= '0;
      v1_q       <= 1'b0;
      c_ld_q     <= 1'b0;
      rd_v_q     <= 1'b0;
      in_range_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      i_q        <= i_d;
      j_q        <= j_d;
      p_q        <= p_d;
      clr_q      <= clr_d;
      v1_q       <= issue;
      c_ld_q     <= (state_q == ST_CRD);
      rd_v_q     <= accept && (mma_op_e'(op_i) == OP_READ_C);
      in_range_q <= in_range;
    end
  end

  assign mac_ctrl.load  = c_ld_q;
  assign mac_ctrl.mul_v = v1_q;

  mma_operand_mem u_operand_mem (
    .clk_i     (clk_i),
    .we_a_i    (op_we_a),
    .we_b_i    (op_we_b),
    .waddr_i   (in_addr),
    .wdata_i   (element_i),
    .re_i      (issue),
    .raddr_a_i (op_raddr_a),
    .raddr_b_i (op_raddr_b),
    .rdata_a_o (a_rd),
    .rdata_b_o (b_rd)
  );

  mma_accum_mem u_accum_mem (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .re_i    (c_re),
    .raddr_i (c_raddr),
    .rdata_o (c_rd)
  );

  mma_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .a_i      (a_rd),
    .b_i      (b_rd),
    .c_acc_i  (c_rd[ACC_BITS-1:0]),
    .c_flag_i (c_rd[ACC_BITS]),
    .acc_o    (mac_acc),
    .flag_o   (mac_flag),
    .busy_o   (mac_busy)
  );

  assign result_valid_o = rd_v_q;
  assign sum_value_o    = in_range_q ? c_rd[ACC_BITS-1:0] : '0;
  assign overflowed_o   = in_range_q & c_rd[ACC_BITS];

`include "assert_macros.svh"

  `ASSERT_IMPL(a_result_after_read, clk_i, rst_ni, result_valid_o,
               $past(start && !busy && op_i == OP_READ_C))
  `ASSERT_IMPL(a_wb_drained, clk_i, rst_ni, state_q == ST_WB, !v1_q && !mac_busy)
  `ASSERT_NEXT(a_crd_loads_acc, clk_i, rst_ni, state_q == ST_CRD,
               state_q == ST_RUN && c_ld_q)

endmodule

[bench/tb_matrix_multiply_accumulate.sv]
`timescale 1ns / 1ps
module tb_matrix_multiply_accumulate;
  import mma_pkg::*;

  localparam int PHASES          = 18;
  localparam int WORDS_PER_PHASE = 92;
  localparam int DIR_N           = 25;

  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_MID   = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  localparam logic [ACC_BITS-1:0] ACC_TOP    = {1'b0, {(ACC_BITS - 1){1'b1}}};
  localparam logic [ACC_BITS-1:0] ACC_BOTTOM = {1'b1, {(ACC_BITS - 1){1'b0}}};
  localparam longint ACC_HI = (longint'(1) <<< (ACC_BITS - 1)) - 1;
  localparam longint ACC_LO = -ACC_HI - 1;

  typedef struct packed {
    logic signed [ACC_BITS-1:0] sum;
    logic                       ovf;
  } c_word_t;

  typedef enum logic [1:0] {ROW_WORD, ROW_TYPED, ROW_CFG} dir_kind_e;

  typedef struct packed {
    dir_kind_e              kind;
    logic [OP_W-1:0]        op;
    logic [COORD_W-1:0]     row;
    logic [COORD_W-1:0]     col;
    logic [ELEM_BITS-1:0]   elem;
    logic [ACC_BITS-1:0]    acc;
    logic                   ovf;
    mma_reg_e               sel;
    logic [DIM_REG_W-1:0]   dim;
  } dir_row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic [OP_W-1:0]               op_i = '0;
  logic [COORD_W-1:0]            row_i = '0;
  logic [COORD_W-1:0]            col_i = '0;
  logic signed [ELEM_BITS-1:0]   element_i = '0;
  logic signed [ACC_BITS-1:0]    acc_init_i = '0;
  logic                          result_valid_o;
  logic signed [ACC_BITS-1:0]    sum_value_o;
  logic                          overflowed_o;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [CFG_AW-1:0]             paddr = '0;
  logic [CFG_DW-1:0]             pwdata = '0;
  logic [CFG_DW-1:0]             prdata;
  logic                          pready;

  int      a_elem [MAX_DIM][MAX_DIM];
  int      b_elem [MAX_DIM][MAX_DIM];
  bit      a_seen [MAX_DIM][MAX_DIM];
  bit      b_seen [MAX_DIM][MAX_DIM];
  longint  c_acc  [MAX_DIM][MAX_DIM];
  bit      c_sat  [MAX_DIM][MAX_DIM];
  logic [DIM_REG_W-1:0] dim_reg [3] = '{7'd1, 7'd1, 7'd1};

  c_word_t  pending_reads [$];
  c_word_t  head;
  dir_row_t directed [DIR_N];
  int       mismatches = 0;
  int       words_sent = 0;
  int       idle_pct = 0;
  bit       start_on = 1'b0;

  matrix_multiply_accumulate DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .row_i          (row_i),
    .col_i          (col_i),
    .element_i      (element_i),
    .acc_init_i     (acc_init_i),
    .result_valid_o (result_valid_o),
    .sum_value_o    (sum_value_o),
    .overflowed_o   (overflowed_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk_i = ~clk_i;

  function automatic void flag_mismatch(string what, longint expv, longint actv);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch on %s: expected %0d, got %0d", what, expv, actv);
    end
  endfunction

  function automatic int dim_eff(logic [DIM_REG_W-1:0] v);
    return (int'(v) > MAX_DIM) ? MAX_DIM : int'(v);
  endfunction

  // Applies one word to the shadow matrices; returns 1 when it yields a C word.
  function automatic bit step_matrices(input logic [OP_W-1:0] op,
                                       input logic [COORD_W-1:0] r,
                                       input logic [COORD_W-1:0] c,
                                       input logic signed [ELEM_BITS-1:0] e,
                                       input logic signed [ACC_BITS-1:0] a,
                                       output c_word_t w);
    int m, n, k;
    longint acc;
    w = '0;
    case (op)
      OP_LOAD_A: begin
        a_elem[r][c] = e;
        a_seen[r][c] = 1'b1;
      end
      OP_LOAD_B: begin
        b_elem[r][c] = e;
        b_seen[r][c] = 1'b1;
      end
      OP_LOAD_C: begin
        c_acc[r][c] = a;
        c_sat[r][c] = 1'b0;
      end
      OP_COMPUTE: begin
        m = dim_eff(dim_reg[REG_ROWS]);
        n = dim_eff(dim_reg[REG_COLS]);
        k = dim_eff(dim_reg[REG_INNER]);
        for (int i = 0; i < m; i++) begin
          for (int j = 0; j < n; j++) begin
            acc = c_acc[i][j];
            for (int p = 0; p < k; p++) begin
              acc += longint'(a_elem[i][p]) * longint'(b_elem[p][j]);
              if (acc > ACC_HI) begin
                acc = ACC_HI;
                c_sat[i][j] = 1'b1;
              end else if (acc < ACC_LO) begin
                acc = ACC_LO;
                c_sat[i][j] = 1'b1;
              end
            end
            c_acc[i][j] = acc;
          end
        end
      end
      OP_READ_C: begin
        w.sum = ACC_BITS'(c_acc[r][c]);
        w.ovf = c_sat[r][c];
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic logic [ELEM_BITS-1:0] rand_elem();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return ELEM_BITS'($urandom());
    endcase
  endfunction

  // Near-limit starting values so short sums still hit saturation.
  function automatic logic [ACC_BITS-1:0] rand_acc();
    logic [ACC_BITS-1:0] off;
    off = ACC_BITS'($urandom());
    case ($urandom_range(0, 3))
      0: return ACC_TOP - off;
      1: return ACC_BOTTOM + off;
      default: return ACC_BITS'({$urandom(), $urandom()});
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] pick(int lim);
    return (lim > 0) ? COORD_W'($urandom_range(0, lim - 1)) : COORD_W'($urandom_range(0, 63));
  endfunction

  task automatic sender_gap();
    int n;
    n = 0;
    while ($urandom_range(0, 99) < idle_pct) n++;
    if (n > 0) begin
      start <= 1'b0;
      start_on = 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic issue_word(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] r,
                            input logic [COORD_W-1:0] c, input logic [ELEM_BITS-1:0] e,
                            input logic [ACC_BITS-1:0] a, input bit typed,
                            input c_word_t typed_w);
    c_word_t w;
    bit has_w;
    op_i <= op;
    row_i <= r;
    col_i <= c;
    element_i <= e;
    acc_init_i <= a;
    start <= 1'b1;
    start_on = 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    has_w = step_matrices(op, r, c, e, a, w);
    if (has_w) pending_reads.push_back(typed ? typed_w : w);
    words_sent++;
    sender_gap();
  endtask

  task automatic hold_until_idle();
    if (start_on) begin
      start <= 1'b0;
      start_on = 1'b0;
    end
    @(posedge clk_i);
    while (pending_reads.size() != 0 || busy) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic program_dims(input logic [DIM_REG_W-1:0] m, input logic [DIM_REG_W-1:0] n,
                              input logic [DIM_REG_W-1:0] k);
    logic [DIM_REG_W-1:0] want [3];
    mma_reg_e regs [3];
    mma_reg_e sel;
    logic [CFG_DW-1:0] data;
    regs = '{REG_ROWS, REG_COLS, REG_INNER};
    want[REG_ROWS] = m;
    want[REG_COLS] = n;
    want[REG_INNER] = k;
    hold_until_idle();
    foreach (regs[i]) begin
      sel = regs[i];
      data = $urandom();
      data[DIM_REG_W-1:0] = want[sel];
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CFG_AW'(4 * int'(sel));
      pwdata <= data;
      @(posedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      while (!pready) @(posedge clk_i);
      dim_reg[sel] = want[sel];
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      while (!pready) @(posedge clk_i);
      if (prdata !== CFG_DW'(want[sel])) flag_mismatch("dimension readback", want[sel], prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // A compute must never touch an operand that was never loaded.
  task automatic fill_operands(int m, int n, int k);
    for (int i = 0; i < m; i++) begin
      for (int p = 0; p < k; p++) begin
        if (!a_seen[i][p]) begin
          issue_word(OP_LOAD_A, COORD_W'(i), COORD_W'(p), rand_elem(), rand_acc(), 1'b0, '0);
        end
      end
    end
    for (int p = 0; p < k; p++) begin
      for (int j = 0; j < n; j++) begin
        if (!b_seen[p][j]) begin
          issue_word(OP_LOAD_B, COORD_W'(p), COORD_W'(j), rand_elem(), rand_acc(), 1'b0, '0);
        end
      end
    end
  endtask

  task automatic random_word(int m, int n, int k);
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      issue_word(OP_LOAD_A, pick(m), pick(k), rand_elem(), rand_acc(), 1'b0, '0);
    end else if (r < 40) begin
      issue_word(OP_LOAD_B, pick(k), pick(n), rand_elem(), rand_acc(), 1'b0, '0);
    end else if (r < 50) begin
      issue_word(OP_LOAD_C, pick(m), pick(n), rand_elem(), rand_acc(), 1'b0, '0);
    end else if (r < 58) begin
      fill_operands(m, n, k);
      issue_word(OP_COMPUTE, pick(0), pick(0), rand_elem(), rand_acc(), 1'b0, '0);
    end else if (r < 92) begin
      issue_word(OP_READ_C, pick(m), pick(n), rand_elem(), rand_acc(), 1'b0, '0);
    end else if (r < 96) begin
      issue_word(OP_W'($urandom_range(OP_LOAD_A, OP_LOAD_C)), pick(0), pick(0), rand_elem(),
                 rand_acc(), 1'b0, '0);
    end else begin
      issue_word(OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), pick(0), pick(0),
                 rand_elem(), rand_acc(), 1'b0, '0);
    end
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (pending_reads.size() == 0) begin
        flag_mismatch("C word with none pending", 0, sum_value_o);
      end else begin
        head = pending_reads.pop_front();
        if (sum_value_o !== head.sum) flag_mismatch("sum_value", head.sum, sum_value_o);
        if (overflowed_o !== head.ovf) flag_mismatch("overflowed", head.ovf, overflowed_o);
      end
    end
  end

  initial begin
    logic [DIM_REG_W-1:0] dims [3];
    logic [DIM_REG_W-1:0] m_r, n_r, k_r;
    int goal;
    directed = '{
      '{ROW_TYPED, OP_READ_C,      6'd0,  6'd0,  16'h0000, 40'h0,      1'b0, REG_ROWS, 7'd0},
      '{ROW_TYPED, OP_READ_C,      6'd63, 6'd63, 16'hffff, 40'h0,      1'b0, REG_ROWS, 7'd0},
      '{ROW_WORD,  OP_LOAD_A,      6'd0,  6'd0,  16'h8000, 40'h0,      1'b0, REG_ROWS, 7'd0},
      '{ROW_WORD,  OP_LOAD_B,      6'd0,  6'd0,  16'h8000, 40'h0,      1'b0, REG_ROWS, 7'd0},
      '{ROW_WORD,  OP_LOAD_C,      6'd0,  6'd0,  16'h0000, ACC_TOP,    1'b0, REG_ROWS, 7'd0},
      '{ROW_WORD,  OP_COMPUTE,     6'd0,  6'd0,  16'h0000, 40'h0,      1'b0, REG_ROWS, 7'd0},
      '{ROW_TYPED, OP_READ_C,      6'd0,  6'd0,  16'h0000, ACC_TOP,    1'b1, REG_ROWS, 7'd0},
      '{ROW_WORD,  OP_LOAD_C,      6'd0,  6'd0,  16'h0000, ACC_BOTTOM, 1'b0, REG_ROWS, 7'd0},
      '{ROW_TYPED, OP_READ_C,      6'd0,  6'd0,  16'h0000, ACC_BOTTOM, 1'b0, REG_ROWS, 7'd0},
      '{ROW_WORD,  OP_LOAD_A,      6'd0,  6'd0,  16'h7fff, 40'h0,      1'b0, REG_ROWS, 7'd0},
      '{ROW_WORD,  OP_COMPUTE,     6'd0,  6'd0,  16'h0000, 40'h0,      1'b0, REG_ROWS, 7'd0},
      '{ROW_TYPED, OP_READ_C,      6'd0,  6'd0,  16'h0000, ACC_BOTTOM, 1'b1, REG_ROWS, 7'd0},
      '{ROW_WORD,  OP_SPARE_FIRST, 6'd63, 6'd63, 16'hffff, {40{1'b1}}, 1'b0, REG_ROWS, 7'd0},
      '{ROW_WORD,  OP_SPARE_MID,   6'd0,  6'd0,  16'h0000, 40'h0,      1'b0, REG_ROWS, 7'd0},
      '{ROW_WORD,  OP_SPARE_LAST,  6'd63, 6'd0,  16'h8000, ACC_TOP,    1'b0, REG_ROWS, 7'd0},
      '{ROW_WORD,  OP_LOAD_C,      6'd0,  6'd0,  16'h0000, 40'h0,      1'b0, REG_ROWS, 7'd0},
      '{ROW_WORD,  OP_LOAD_B,      6'd0,  6'd0,  16'h7fff, 40'h0,      1'b0, REG_ROWS, 7'd0},
      '{ROW_WORD,  OP_LOAD_C,      6'd63, 6'd63, 16'h0000, ACC_TOP,    1'b0, REG_ROWS, 7'd0},
      '{ROW_TYPED, OP_READ_C,      6'd63, 6'd63, 16'h0000, ACC_TOP,    1'b0, REG_ROWS, 7'd0},
      '{ROW_WORD,  OP_COMPUTE,     6'd0,  6'd0,  16'h0000, 40'h0,      1'b0, REG_ROWS, 7'd0},
      '{ROW_WORD,  OP_READ_C,      6'd0,  6'd0,  16'h0000, 40'h0,      1'b0, REG_ROWS, 7'd0},
      '{ROW_CFG,   OP_LOAD_A,      6'd0,  6'd0,  16'h0000, 40'h0,      1'b0, REG_ROWS, 7'd0},
      '{ROW_WORD,  OP_COMPUTE,     6'd0,  6'd0,  16'h0000, 40'h0,      1'b0, REG_ROWS, 7'd0},
      '{ROW_WORD,  OP_READ_C,      6'd0,  6'd0,  16'h0000, 40'h0,      1'b0, REG_ROWS, 7'd0},
      '{ROW_CFG,   OP_LOAD_A,      6'd0,  6'd0,  16'h0000, 40'h0,      1'b0, REG_ROWS, 7'd1}
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        dims = dim_reg;
        dims[directed[i].sel] = directed[i].dim;
        program_dims(dims[REG_ROWS], dims[REG_COLS], dims[REG_INNER]);
      end else begin
        issue_word(directed[i].op, directed[i].row, directed[i].col, directed[i].elem,
                   directed[i].acc, directed[i].kind == ROW_TYPED,
                   {directed[i].acc, directed[i].ovf});
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin m_r = 7'd127; n_r = 7'd1;   k_r = 7'd1;   end
        1: begin m_r = 7'd1;   n_r = 7'd127; k_r = 7'd2;   end
        2: begin m_r = 7'd2;   n_r = 7'd1;   k_r = 7'd127; end
        3: begin m_r = 7'd64;  n_r = 7'd2;   k_r = 7'd2;   end
        4: begin m_r = 7'd3;   n_r = 7'd0;   k_r = 7'd2;   end
        5: begin m_r = 7'd2;   n_r = 7'd3;   k_r = 7'd0;   end
        default: begin
          m_r = DIM_REG_W'($urandom_range(1, 4));
          n_r = DIM_REG_W'($urandom_range(1, 4));
          k_r = DIM_REG_W'($urandom_range(1, 4));
          if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 2))
              0: m_r = 7'd0;
              1: n_r = 7'd0;
              default: k_r = 7'd0;
            endcase
          end
        end
      endcase
      program_dims(m_r, n_r, k_r);
      case (ph % 3)
        0: idle_pct = 0;
        1: idle_pct = 79;
        default: idle_pct = 10;
      endcase
      goal = words_sent + WORDS_PER_PHASE;
      while (words_sent < goal) random_word(dim_eff(m_r), dim_eff(n_r), dim_eff(k_r));
    end

    hold_until_idle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending_reads.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(64'd20_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
